/* hdl/psg_pkg.sv */
package psg_pkg;

   localparam int ID_W       = 10;
   localparam int SEG_W      = 10;
   localparam int CNT_W      = 11;
   localparam int LEN_W      = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_LIMIT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_LIMIT   = 4'd1;

   localparam logic [LEN_W-1:0] LENGTH_LIMIT_RST = 32'hFFFF_FFFF;
   localparam logic [CNT_W-1:0] NODE_LIMIT_RST   = 11'd32;

endpackage

/* hdl/psg_if.sv */
interface psg_req_if #(parameter int COORD_BITS = 16);
   logic                       valid;
   logic                       ready;
   logic [psg_pkg::ID_W-1:0]   node_id;
   logic [COORD_BITS-1:0]      pos_x;
   logic [COORD_BITS-1:0]      pos_y;
   logic                       path_end;

   modport source (output valid, node_id, pos_x, pos_y, path_end, input ready);
   modport sink   (input valid, node_id, pos_x, pos_y, path_end, output ready);
endinterface

interface psg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [psg_pkg::SEG_W-1:0]   segment_id;
   logic [psg_pkg::ID_W-1:0]    first_node;
   logic [psg_pkg::ID_W-1:0]    final_node;
   logic [psg_pkg::CNT_W-1:0]   node_count;
   logic [psg_pkg::LEN_W-1:0]   segment_length;

   modport source (output valid, segment_id, first_node, final_node, node_count,
                   segment_length, input ready);
   modport sink   (input valid, segment_id, first_node, final_node, node_count,
                   segment_length, output ready);
endinterface

interface psg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [psg_pkg::CSR_IDX_W-1:0]    index;
   logic [psg_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/psg_sqrt.sv */
module psg_sqrt #(
   parameter int RAD_W = 41
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [RAD_W-1:0]              radicand,
   output logic                          done,
   output logic [(RAD_W+1)/2-1:0]        root
);

   localparam int RES_W = (RAD_W + 1) / 2;
   localparam int PAD_W = 2 * RES_W;
   localparam int CNT_W = $clog2(RES_W + 1);

   logic [PAD_W-1:0] rad_ff;
   logic [RES_W:0]   rem_ff;
   logic [RES_W-1:0] root_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [RES_W+1:0] rem_sh;
   logic [RES_W+1:0] trial;
   logic             fits;

   assign rem_sh = {rem_ff[RES_W-1:0], rad_ff[PAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= PAD_W'(radicand);
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= CNT_W'(RES_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rad_ff <= {rad_ff[PAD_W-3:0], 2'b00};
            if (fits) begin
               rem_ff  <= (RES_W+1)'(rem_sh - trial);
               root_ff <= {root_ff[RES_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh[RES_W:0];
               root_ff <= {root_ff[RES_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* hdl/path_length_segmenter_top.sv */
// channel | role   | payload
// req_ch  | sink   | node_id, pos_x, pos_y, path_end
// rsp_ch  | source | segment_id, first_node, final_node, node_count, segment_length
// csr_ch  | sink   | index, data (0: length_limit, 1: node_limit)
//
// Each node goes through these steps in order: accept, two passes through the
// shared squarer, one root bit per cycle from the square-root unit, then the
// segment update. The first node of a path skips the squarer and the root.
// Synchronous reset clears the path state and restores the register defaults.
// req_ch.ready is low while a node is in work; a held result stalls only the update.
module path_length_segmenter_top #(
   parameter int MAX_NODES  = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   psg_req_if.sink         req_ch,
   psg_rsp_if.source       rsp_ch,
   psg_csr_if.sink         csr_ch
);

   localparam int ID_W   = psg_pkg::ID_W;
   localparam int SEG_W  = psg_pkg::SEG_W;
   localparam int CNT_W  = psg_pkg::CNT_W;
   localparam int LEN_W  = psg_pkg::LEN_W;
   localparam int SUM_W  = 2 * COORD_BITS + 1;
   localparam int RAD_W  = SUM_W + 8;
   localparam int RES_W  = (RAD_W + 1) / 2;
   localparam int CLAMP  = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
   localparam logic [CNT_W-1:0] NODE_CLAMP = CNT_W'(CLAMP);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_DECIDE
   } state_type;

   state_type             state_ff;
   logic [LEN_W-1:0]      len_limit_ff;
   logic [CNT_W-1:0]      node_limit_ff;

   logic                  path_open_ff;
   logic [COORD_BITS-1:0] prev_x_ff;
   logic [COORD_BITS-1:0] prev_y_ff;
   logic [ID_W-1:0]       prev_node_ff;
   logic [ID_W-1:0]       start_node_ff;
   logic [LEN_W-1:0]      run_length_ff;
   logic [CNT_W-1:0]      run_count_ff;
   logic [SEG_W-1:0]      emitted_ff;

   logic [ID_W-1:0]       id_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic                  end_ff;
   logic [COORD_BITS-1:0] dx_ff;
   logic [COORD_BITS-1:0] dy_ff;
   logic [SUM_W-1:0]      acc_ff;
   logic [RES_W-1:0]      hop_ff;

   logic                  rsp_valid_ff;
   logic [SEG_W-1:0]      rsp_seg_ff;
   logic [ID_W-1:0]       rsp_first_ff;
   logic [ID_W-1:0]       rsp_final_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic [LEN_W-1:0]      rsp_len_ff;

   logic [COORD_BITS-1:0]   dx_in;
   logic [COORD_BITS-1:0]   dy_in;
   logic [COORD_BITS-1:0]   mul_op;
   logic [2*COORD_BITS-1:0] prod;
   logic [SUM_W-1:0]        acc_in;
   logic                    sq_start;
   logic                    sq_done;
   logic [RES_W-1:0]        sq_root;

   logic [LEN_W:0]        len_cand;
   logic [LEN_W-1:0]      len_sat;
   logic [CNT_W:0]        cnt_cand;
   logic [CNT_W-1:0]      lim;
   logic                  cut;
   logic                  emit_cut;
   logic                  emit_last;
   logic                  emit;
   logic                  out_free;
   logic                  rsp_load;
   logic                  req_take;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign dx_in = (req_ch.pos_x >= prev_x_ff) ? req_ch.pos_x - prev_x_ff
                                              : prev_x_ff - req_ch.pos_x;
   assign dy_in = (req_ch.pos_y >= prev_y_ff) ? req_ch.pos_y - prev_y_ff
                                              : prev_y_ff - req_ch.pos_y;

   assign mul_op   = (state_ff == ST_SQ_X) ? dx_ff : dy_ff;
   assign prod     = mul_op * mul_op;
   assign acc_in   = ((state_ff == ST_SQ_X) ? '0 : acc_ff) + SUM_W'(prod);
   assign sq_start = (state_ff == ST_SQ_Y);

   psg_sqrt #(.RAD_W(RAD_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ({acc_in, 8'b0}),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign len_cand  = {1'b0, run_length_ff} + (LEN_W+1)'(hop_ff);
   assign len_sat   = len_cand[LEN_W] ? '1 : len_cand[LEN_W-1:0];
   assign cnt_cand  = {1'b0, run_count_ff} + 1'b1;
   assign lim       = (node_limit_ff > NODE_CLAMP) ? NODE_CLAMP : node_limit_ff;
   assign cut       = (len_sat > len_limit_ff) || (cnt_cand > {1'b0, lim});
   assign emit_cut  = path_open_ff && cut && (run_count_ff >= CNT_W'(2));
   assign emit_last = end_ff && path_open_ff && !cut;
   assign emit      = emit_cut || emit_last;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load  = (state_ff == ST_DECIDE) && emit && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_limit_ff  <= psg_pkg::LENGTH_LIMIT_RST;
         node_limit_ff <= psg_pkg::NODE_LIMIT_RST;
         path_open_ff  <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_node_ff  <= '0;
         start_node_ff <= '0;
         run_length_ff <= '0;
         run_count_ff  <= '0;
         emitted_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               psg_pkg::CSR_LENGTH_LIMIT: len_limit_ff  <= csr_ch.data[LEN_W-1:0];
               psg_pkg::CSR_NODE_LIMIT:   node_limit_ff <= csr_ch.data[CNT_W-1:0];
               default: ;
            endcase
         end

         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ch.ready);

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  id_ff    <= req_ch.node_id;
                  x_ff     <= req_ch.pos_x;
                  y_ff     <= req_ch.pos_y;
                  end_ff   <= req_ch.path_end;
                  dx_ff    <= dx_in;
                  dy_ff    <= dy_in;
                  state_ff <= path_open_ff ? ST_SQ_X : ST_DECIDE;
               end
            end
            ST_SQ_X: begin
               acc_ff   <= acc_in;
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (sq_done) begin
                  hop_ff   <= sq_root;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (!emit || out_free) begin
                  if (emit) begin
                     rsp_seg_ff   <= emitted_ff;
                     rsp_first_ff <= start_node_ff;
                     rsp_final_ff <= emit_cut ? prev_node_ff : id_ff;
                     rsp_count_ff <= emit_cut ? run_count_ff : cnt_cand[CNT_W-1:0];
                     rsp_len_ff   <= emit_cut ? run_length_ff : len_sat;
                  end
                  if (end_ff) begin
                     path_open_ff  <= 1'b0;
                     prev_x_ff     <= '0;
                     prev_y_ff     <= '0;
                     prev_node_ff  <= '0;
                     start_node_ff <= '0;
                     run_length_ff <= '0;
                     run_count_ff  <= '0;
                     emitted_ff    <= '0;
                  end else begin
                     prev_x_ff    <= x_ff;
                     prev_y_ff    <= y_ff;
                     prev_node_ff <= id_ff;
                     if (!path_open_ff) begin
                        path_open_ff  <= 1'b1;
                        start_node_ff <= id_ff;
                        run_length_ff <= '0;
                        run_count_ff  <= CNT_W'(1);
                        emitted_ff    <= '0;
                     end else if (cut) begin
                        start_node_ff <= id_ff;
                        run_length_ff <= '0;
                        run_count_ff  <= CNT_W'(1);
                        emitted_ff    <= emitted_ff + SEG_W'(emit_cut);
                     end else begin
                        run_length_ff <= len_sat;
                        run_count_ff  <= cnt_cand[CNT_W-1:0];
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.segment_id     = rsp_seg_ff;
   assign rsp_ch.first_node     = rsp_first_ff;
   assign rsp_ch.final_node     = rsp_final_ff;
   assign rsp_ch.node_count     = rsp_count_ff;
   assign rsp_ch.segment_length = rsp_len_ff;

endmodule
